/* rtl/core/cam_pkg.sv */
// Shared types and constants of the Cantor pairing affine codec.
// No dependencies; the other files of the block that use it refer to this package by scoped names.
package cam_pkg;

  localparam int CODE_W  = 30;
  localparam int INDEX_W = 59;
  localparam int RESULT_W = 63;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_MODULUS_A    = 3'd0,
    CFG_MULTIPLIER_A = 3'd1,
    CFG_ADDEND_A     = 3'd2,
    CFG_INVERSE_A    = 3'd3,
    CFG_MODULUS_B    = 3'd4,
    CFG_MULTIPLIER_B = 3'd5,
    CFG_ADDEND_B     = 3'd6,
    CFG_INVERSE_B    = 3'd7
  } cfg_index_t;

  localparam logic [CODE_W-1:0] RST_MODULUS    = 30'd48773177;
  localparam logic [CODE_W-1:0] RST_MULTIPLIER = 30'd48771253;
  localparam logic [CODE_W-1:0] RST_ADDEND     = 30'd38748171;
  localparam logic [CODE_W-1:0] RST_INVERSE    = 30'd39368370;

  typedef struct packed {
    logic              mode;
    logic [INDEX_W-1:0] index_in;
    logic [CODE_W-1:0] code_a_in;
    logic [CODE_W-1:0] code_b_in;
    logic [CODE_W-1:0] offset;
  } in_t;

  typedef struct packed {
    logic signed [RESULT_W-1:0] index_out;
    logic [CODE_W-1:0]          code_a_out;
    logic [CODE_W-1:0]          code_b_out;
    logic                       not_invertible;
  } out_t;

  typedef struct packed {
    logic [CODE_W-1:0] modulus_a;
    logic [CODE_W-1:0] multiplier_a;
    logic [CODE_W-1:0] addend_a;
    logic [CODE_W-1:0] inverse_a;
    logic [CODE_W-1:0] modulus_b;
    logic [CODE_W-1:0] multiplier_b;
    logic [CODE_W-1:0] addend_b;
    logic [CODE_W-1:0] inverse_b;
  } cfg_t;

endpackage

/* rtl/core/cam_delay.sv */
// Enabled delay line of fixed depth for side data of the codec pipeline.
// No package dependencies.
module cam_delay #(
  parameter int W = 1,
  parameter int D = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] line [D];

  always_ff @(posedge clk) begin
    if (en) begin
      line[0] <= d;
      for (int i = 1; i < D; i++) begin
        line[i] <= line[i-1];
      end
    end
  end

  assign q = line[D-1];

endmodule

/* rtl/core/cam_queue.sv */
// Front of the codec: accepts input items into a short queue ahead of the datapath.
// Depends on cam_pkg for the input item type.
module cam_queue #(
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push_valid,
  output logic         push_stall,
  input  cam_pkg::in_t push_data,
  output logic         pop_valid,
  input  logic         pop_take,
  output cam_pkg::in_t pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cam_pkg::in_t     mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_stall = (count == CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && !push_stall;
  assign pop        = pop_valid && pop_take;
  assign pop_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

/* rtl/core/cam_sqrt.sv */
// Pipelined floor square root of a 64-bit radicand, one root bit per stage.
// No package dependencies.
module cam_sqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] radicand,
  output logic [31:0] root
);

  logic [63:0] rad_q  [32];
  logic [33:0] rem_q  [32];
  logic [31:0] root_q [32];

  for (genvar i = 0; i < 32; i++) begin : g_stage
    logic [63:0] rad_c;
    logic [33:0] rem_c;
    logic [31:0] root_c;
    logic [35:0] t;
    logic [35:0] trial;
    logic        ge;

    if (i == 0) begin : g_first
      assign rad_c  = radicand;
      assign rem_c  = '0;
      assign root_c = '0;
    end else begin : g_next
      assign rad_c  = rad_q[i-1];
      assign rem_c  = rem_q[i-1];
      assign root_c = root_q[i-1];
    end

    assign t     = {rem_c, rad_c[63-2*i -: 2]};
    assign trial = {2'b00, root_c, 2'b01};
    assign ge    = (t >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        rad_q[i]  <= rad_c;
        rem_q[i]  <= ge ? 34'(t - trial) : t[33:0];
        root_q[i] <= {root_c[30:0], ge};
      end
    end
  end

  assign root = root_q[31];

endmodule

/* rtl/core/cam_rem.sv */
// Pipelined restoring remainder of a W-bit dividend by a code-wide divisor.
// Depends on cam_pkg for the code width.
module cam_rem #(
  parameter int W = 30
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [W-1:0]               dividend,
  input  logic [cam_pkg::CODE_W-1:0] divisor,
  output logic [cam_pkg::CODE_W-1:0] remainder
);

  localparam int CW = cam_pkg::CODE_W;

  logic [W-1:0]  dv_q [W];
  logic [CW-1:0] rm_q [W];

  for (genvar i = 0; i < W; i++) begin : g_stage
    logic [W-1:0]  dv_c;
    logic [CW-1:0] rm_c;
    logic [CW:0]   t;
    logic          ge;

    if (i == 0) begin : g_first
      assign dv_c = dividend;
      assign rm_c = '0;
    end else begin : g_next
      assign dv_c = dv_q[i-1];
      assign rm_c = rm_q[i-1];
    end

    assign t  = {rm_c, dv_c[W-1-i]};
    assign ge = (t >= {1'b0, divisor});

    always_ff @(posedge clk) begin
      if (en) begin
        dv_q[i] <= dv_c;
        rm_q[i] <= ge ? CW'(t - {1'b0, divisor}) : t[CW-1:0];
      end
    end
  end

  assign remainder = rm_q[W-1];

endmodule

/* rtl/core/cam_back.sv */
// Back of the codec: the pipelined encode and decode datapath with its output register.
// Depends on cam_pkg, cam_delay, cam_sqrt and cam_rem.
module cam_back (
  input  logic          clk,
  input  logic          rst,
  input  cam_pkg::cfg_t cfg,
  input  logic          item_valid,
  input  cam_pkg::in_t  item,
  output logic          take,
  output logic          out_valid,
  input  logic          out_stall,
  output cam_pkg::out_t out_data
);

  localparam int CW      = cam_pkg::CODE_W;
  localparam int SQ_ST   = 32;
  localparam int ENC_PRE = SQ_ST + 3;
  localparam int DEC_PRE = CW + 2;
  localparam int BIG_W   = 62;
  localparam int LAT     = ENC_PRE + BIG_W + 3;

  logic adv;
  logic [LAT-1:0] vs;

  // The whole pipeline moves unless a finished result is held back.
  assign adv       = !(out_valid && out_stall);
  assign take      = adv;
  assign out_valid = vs[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vs <= '0;
    end else if (adv) begin
      vs <= {vs[LAT-2:0], item_valid};
    end
  end

  cam_pkg::in_t s0;
  always_ff @(posedge clk) begin
    if (adv) begin
      s0 <= item;
    end
  end

  // Encode: split p = index + offset with the inverse Cantor pairing.
  logic [59:0] p0;
  logic [59:0] p32;
  logic [31:0] root32;
  assign p0 = {1'b0, s0.index_in} + 60'(s0.offset);

  cam_sqrt u_sqrt (
    .clk(clk), .en(adv), .radicand({1'b0, p0, 3'b001}), .root(root32)
  );
  cam_delay #(.W(60), .D(SQ_ST)) u_dly_p (.clk(clk), .en(adv), .d(p0), .q(p32));

  logic [30:0] z_c;
  logic [31:0] zp1_c;
  logic [62:0] zz_c;
  logic [30:0] z33;
  logic [62:0] zz33;
  logic [59:0] p33;
  assign z_c   = 31'((root32 - 32'd1) >> 1);
  assign zp1_c = {1'b0, z_c} + 32'd1;
  assign zz_c  = z_c * zp1_c;

  always_ff @(posedge clk) begin
    if (adv) begin
      z33  <= z_c;
      zz33 <= zz_c;
      p33  <= p32;
    end
  end

  logic [30:0] u_c;
  logic [30:0] u34;
  logic [30:0] v34;
  logic        flag34;
  assign u_c = 31'(p33 - zz33[60:1]);

  always_ff @(posedge clk) begin
    if (adv) begin
      u34    <= u_c;
      v34    <= z33 - u_c;
      flag34 <= (u_c >= {1'b0, cfg.modulus_a}) || ((z33 - u_c) >= {1'b0, cfg.modulus_b});
    end
  end

  logic [60:0]      mpa_c;
  logic [60:0]      mpb_c;
  logic [BIG_W-1:0] pa35;
  logic [BIG_W-1:0] pb35;
  assign mpa_c = u34 * cfg.multiplier_a;
  assign mpb_c = v34 * cfg.multiplier_b;

  always_ff @(posedge clk) begin
    if (adv) begin
      pa35 <= {1'b0, mpa_c} + BIG_W'(cfg.addend_a);
      pb35 <= {1'b0, mpb_c} + BIG_W'(cfg.addend_b);
    end
  end

  // Decode: reduce code, addend and inverse, then form (c - s) * inverse.
  logic [CW-1:0] cra, sra, ira, crb, srb, irb;
  cam_rem #(.W(CW)) u_rem_ca (.clk(clk), .en(adv), .dividend(s0.code_a_in),
                              .divisor(cfg.modulus_a), .remainder(cra));
  cam_rem #(.W(CW)) u_rem_sa (.clk(clk), .en(adv), .dividend(cfg.addend_a),
                              .divisor(cfg.modulus_a), .remainder(sra));
  cam_rem #(.W(CW)) u_rem_ia (.clk(clk), .en(adv), .dividend(cfg.inverse_a),
                              .divisor(cfg.modulus_a), .remainder(ira));
  cam_rem #(.W(CW)) u_rem_cb (.clk(clk), .en(adv), .dividend(s0.code_b_in),
                              .divisor(cfg.modulus_b), .remainder(crb));
  cam_rem #(.W(CW)) u_rem_sb (.clk(clk), .en(adv), .dividend(cfg.addend_b),
                              .divisor(cfg.modulus_b), .remainder(srb));
  cam_rem #(.W(CW)) u_rem_ib (.clk(clk), .en(adv), .dividend(cfg.inverse_b),
                              .divisor(cfg.modulus_b), .remainder(irb));

  logic [CW:0]   da_c;
  logic [CW:0]   db_c;
  logic [CW-1:0] da31, db31, ia31, ib31;
  assign da_c = (cra >= sra) ? ({1'b0, cra} - {1'b0, sra})
                             : ({1'b0, cra} + {1'b0, cfg.modulus_a} - {1'b0, sra});
  assign db_c = (crb >= srb) ? ({1'b0, crb} - {1'b0, srb})
                             : ({1'b0, crb} + {1'b0, cfg.modulus_b} - {1'b0, srb});

  always_ff @(posedge clk) begin
    if (adv) begin
      da31 <= da_c[CW-1:0];
      db31 <= db_c[CW-1:0];
      ia31 <= ira;
      ib31 <= irb;
    end
  end

  logic [2*CW-1:0] qa32, qb32, qa35, qb35;
  always_ff @(posedge clk) begin
    if (adv) begin
      qa32 <= da31 * ia31;
      qb32 <= db31 * ib31;
    end
  end
  cam_delay #(.W(2*CW), .D(ENC_PRE - DEC_PRE)) u_dly_qa (.clk(clk), .en(adv),
                                                        .d(qa32), .q(qa35));
  cam_delay #(.W(2*CW), .D(ENC_PRE - DEC_PRE)) u_dly_qb (.clk(clk), .en(adv),
                                                        .d(qb32), .q(qb35));

  // Shared final reduction for both modes.
  logic          mode35;
  logic          mode98;
  logic [CW-1:0] ra97, rb97;
  cam_delay #(.W(1), .D(ENC_PRE)) u_dly_m0 (.clk(clk), .en(adv), .d(s0.mode), .q(mode35));
  cam_delay #(.W(1), .D(BIG_W + 1)) u_dly_m1 (.clk(clk), .en(adv), .d(mode35), .q(mode98));

  cam_rem #(.W(BIG_W)) u_rem_big_a (.clk(clk), .en(adv),
    .dividend(mode35 ? BIG_W'(qa35) : pa35), .divisor(cfg.modulus_a), .remainder(ra97));
  cam_rem #(.W(BIG_W)) u_rem_big_b (.clk(clk), .en(adv),
    .dividend(mode35 ? BIG_W'(qb35) : pb35), .divisor(cfg.modulus_b), .remainder(rb97));

  logic          flag98;
  logic [CW-1:0] off98;
  cam_delay #(.W(1), .D(LAT - 2 - 34)) u_dly_f (.clk(clk), .en(adv), .d(flag34), .q(flag98));
  cam_delay #(.W(CW), .D(LAT - 2)) u_dly_o (.clk(clk), .en(adv), .d(s0.offset), .q(off98));

  logic [CW-1:0] xa_c, xb_c;
  logic [CW:0]   zd_c;
  logic [CW+1:0] zdp1_c;
  logic [62:0]   zzd_c;
  logic [62:0]   zz98;
  logic [CW-1:0] xa98, xb98;
  assign xa_c   = (cfg.modulus_a == '0) ? '0 : ra97;
  assign xb_c   = (cfg.modulus_b == '0) ? '0 : rb97;
  assign zd_c   = {1'b0, xa_c} + {1'b0, xb_c};
  assign zdp1_c = {1'b0, zd_c} + (CW+2)'(1);
  assign zzd_c  = zd_c * zdp1_c;

  always_ff @(posedge clk) begin
    if (adv) begin
      zz98 <= zzd_c;
      xa98 <= xa_c;
      xb98 <= xb_c;
    end
  end

  logic [62:0] idx_c;
  assign idx_c = {1'b0, zz98[62:1]} + 63'(xa98) - 63'(off98);

  always_ff @(posedge clk) begin
    if (adv) begin
      if (mode98) begin
        out_data.index_out      <= idx_c;
        out_data.code_a_out     <= '0;
        out_data.code_b_out     <= '0;
        out_data.not_invertible <= 1'b0;
      end else begin
        out_data.index_out      <= '0;
        out_data.code_a_out     <= xa98;
        out_data.code_b_out     <= xb98;
        out_data.not_invertible <= flag98;
      end
    end
  end

endmodule

/* rtl/core/cantor_affine_mod_codec.sv */
// Top level of the keyed Cantor pairing affine codec: configuration registers,
// input queue and pipelined datapath. Depends on cam_pkg, cam_queue and cam_back.
//
//   Channel   Signals                              Direction  Transfer when
//   input     in_valid, in_stall, in_data          in         in_valid && !in_stall
//   output    out_valid, out_stall, out_data       out        out_valid && !out_stall
//   config    cfg_valid, cfg_ready, cfg_index,     in         cfg_valid && cfg_ready
//             cfg_data
//
// One item transfer is accepted per cycle while the queue has room, and one result
// leaves per cycle while out_stall is low. The time an item spends in the datapath
// after it leaves the queue is set by the 32-stage square root, the 62-stage remainder
// pipelines of the affine reduction and the multiply stages around them.
// Reset is synchronous and clears the queue, the valid bits of the pipeline and
// the configuration registers to their default keys.
// While a result waits on out_stall the datapath holds; the queue keeps taking
// input transfers until it is full, and only then raises in_stall.
module cantor_affine_mod_codec #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  cam_pkg::in_t               in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output cam_pkg::out_t              out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [2:0]                 cfg_index,
  input  logic [cam_pkg::CODE_W-1:0] cfg_data
);

  cam_pkg::cfg_t cfg;
  cam_pkg::in_t  q_data;
  logic          q_valid;
  logic          q_take;

  // Configuration writes are always taken; the key registers feed the datapath directly,
  // so they must only change while no item is in flight; the block does not enforce this.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.modulus_a    <= cam_pkg::RST_MODULUS;
      cfg.multiplier_a <= cam_pkg::RST_MULTIPLIER;
      cfg.addend_a     <= cam_pkg::RST_ADDEND;
      cfg.inverse_a    <= cam_pkg::RST_INVERSE;
      cfg.modulus_b    <= cam_pkg::RST_MODULUS;
      cfg.multiplier_b <= cam_pkg::RST_MULTIPLIER;
      cfg.addend_b     <= cam_pkg::RST_ADDEND;
      cfg.inverse_b    <= cam_pkg::RST_INVERSE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cam_pkg::cfg_index_t'(cfg_index))
        cam_pkg::CFG_MODULUS_A:    cfg.modulus_a    <= cfg_data;
        cam_pkg::CFG_MULTIPLIER_A: cfg.multiplier_a <= cfg_data;
        cam_pkg::CFG_ADDEND_A:     cfg.addend_a     <= cfg_data;
        cam_pkg::CFG_INVERSE_A:    cfg.inverse_a    <= cfg_data;
        cam_pkg::CFG_MODULUS_B:    cfg.modulus_b    <= cfg_data;
        cam_pkg::CFG_MULTIPLIER_B: cfg.multiplier_b <= cfg_data;
        cam_pkg::CFG_ADDEND_B:     cfg.addend_b     <= cfg_data;
        cam_pkg::CFG_INVERSE_B:    cfg.inverse_b    <= cfg_data;
        default: ;
      endcase
    end
  end

  // The queue parts the input handshake from the datapath, so the datapath can
  // hold on a stalled result without blocking the sender at once.
  cam_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (in_valid),
    .push_stall (in_stall),
    .push_data  (in_data),
    .pop_valid  (q_valid),
    .pop_take   (q_take),
    .pop_data   (q_data)
  );

  // The datapath runs both modes through shared remainder pipelines.
  cam_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (q_valid),
    .item       (q_data),
    .take       (q_take),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

/* tb/cantor_affine_mod_codec_test.sv */
// Self-checking testbench for cantor_affine_mod_codec: a queue-fed driver, a result
// monitor and a software predictor of the pairing and affine maps. Depends on cam_pkg.
module cantor_affine_mod_codec_test;

  // Time in cycles that the datapath holds an item after it leaves the queue.
  localparam int LATENCY = 100;
  localparam longint CYCLE_LIMIT = 600000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  cam_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  cam_pkg::out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [cam_pkg::CODE_W-1:0] cfg_data = '0;

  cantor_affine_mod_codec uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // The predictor keeps its own copy of the eight key registers.
  cam_pkg::cfg_t keys;

  cam_pkg::in_t pending_items[$];
  cam_pkg::out_t expected_results[$];
  int mismatches = 0;
  longint cycles = 0;
  bit stim_done = 0;

  // Exact floor square root of a 64-bit value, one result bit per step.
  function automatic logic [63:0] isqrt64(logic [63:0] n);
    logic [63:0] root;
    logic [63:0] bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // Forward affine map; products stay within 60 bits so 64-bit arithmetic is exact.
  function automatic logic [29:0] affine_fwd(logic [63:0] x, logic [29:0] m,
                                             logic [29:0] s, logic [29:0] md);
    logic [63:0] t;
    if (md == 0) return '0;
    t = x * m + s;
    return 30'(t % md);
  endfunction

  function automatic logic [63:0] affine_back(logic [29:0] c, logic [29:0] s,
                                              logic [29:0] inv, logic [29:0] md);
    logic [63:0] cr, sr, d;
    if (md == 0) return 0;
    cr = c % md;
    sr = s % md;
    d = (cr >= sr) ? (cr - sr) : (cr + md - sr);
    return (d * (inv % md)) % md;
  endfunction

  function automatic cam_pkg::out_t predict_codes(cam_pkg::in_t it);
    cam_pkg::out_t r;
    logic [63:0] p, root, z, u, v, xa, xb, pr;
    r = '0;
    if (it.mode == 1'b0) begin
      p = it.index_in + it.offset;
      root = isqrt64(8 * p + 1);
      if (!root[0]) root = root - 1;
      z = (root - 1) / 2;
      u = p - (z * (z + 1)) / 2;
      v = z - u;
      r.not_invertible = (u >= keys.modulus_a) || (v >= keys.modulus_b);
      r.code_a_out = affine_fwd(u, keys.multiplier_a, keys.addend_a, keys.modulus_a);
      r.code_b_out = affine_fwd(v, keys.multiplier_b, keys.addend_b, keys.modulus_b);
    end else begin
      xa = affine_back(it.code_a_in, keys.addend_a, keys.inverse_a, keys.modulus_a);
      xb = affine_back(it.code_b_in, keys.addend_b, keys.inverse_b, keys.modulus_b);
      z = xa + xb;
      pr = (z * (z + 1)) / 2 + xa;
      r.index_out = 63'(pr - it.offset);
    end
    return r;
  endfunction

  // The driver decides at the falling edge, so it keeps the stall seen at the last
  // rising edge to know whether the current item was taken.
  logic in_stall_q = 1'b1;
  always @(posedge clk) in_stall_q <= in_stall;

  // Driver: one item per transfer, with a random gap drawn for each item. A gap of
  // zero presents the next item right behind the one just taken.
  int in_gap = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall_q) begin
        in_gap = $urandom_range(0, 12) * ($urandom_range(0, 3) != 0);
        if (in_gap == 0 && pending_items.size() > 0) begin
          in_data <= pending_items.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end else if (!in_valid) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_items.size() > 0) begin
          in_data <= pending_items.pop_front();
          in_valid <= 1'b1;
        end
      end
    end
  end

  // Monitor: checks each result transfer against the oldest prediction.
  int out_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", out_data);
        end else begin
          cam_pkg::out_t e;
          e = expected_results.pop_front();
          if (e !== out_data) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: expected idx=%0d a=%0d b=%0d f=%0b",
                        " got idx=%0d a=%0d b=%0d f=%0b"},
                       e.index_out, e.code_a_out, e.code_b_out, e.not_invertible,
                       out_data.index_out, out_data.code_a_out, out_data.code_b_out,
                       out_data.not_invertible);
          end
        end
      end
    end
  end

  // The stall draws a wait per result; stretches with no stall come from zero draws.
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (out_valid && !out_stall)
        out_gap = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 12) : 0;
    end
  end

  // Queue an item and its prediction. Predictions are made in order at queue time,
  // which is valid because keys only change while everything is drained.
  task automatic push_item(cam_pkg::in_t it);
    pending_items.push_back(it);
    expected_results.push_back(predict_codes(it));
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
  endtask

  task automatic write_key(cam_pkg::cfg_index_t idx, logic [29:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      cam_pkg::CFG_MODULUS_A:    keys.modulus_a = val;
      cam_pkg::CFG_MULTIPLIER_A: keys.multiplier_a = val;
      cam_pkg::CFG_ADDEND_A:     keys.addend_a = val;
      cam_pkg::CFG_INVERSE_A:    keys.inverse_a = val;
      cam_pkg::CFG_MODULUS_B:    keys.modulus_b = val;
      cam_pkg::CFG_MULTIPLIER_B: keys.multiplier_b = val;
      cam_pkg::CFG_ADDEND_B:     keys.addend_b = val;
      default:                   keys.inverse_b = val;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic cam_pkg::in_t rand_item(bit small_vals);
    cam_pkg::in_t it;
    it.mode = 1'($urandom_range(0, 1));
    it.index_in = 59'({$urandom, $urandom});
    it.code_a_in = 30'($urandom);
    it.code_b_in = 30'($urandom);
    it.offset = 30'($urandom);
    if (small_vals) begin
      it.index_in = 59'($urandom_range(0, 5000));
      it.offset = 30'($urandom_range(0, 50));
    end
    return it;
  endfunction

  task automatic rand_phase(int n);
    for (int i = 0; i < n; i++) push_item(rand_item($urandom_range(0, 3) == 0));
  endtask

  initial begin
    cam_pkg::in_t it;
    keys = '{cam_pkg::RST_MODULUS, cam_pkg::RST_MULTIPLIER,
             cam_pkg::RST_ADDEND, cam_pkg::RST_INVERSE,
             cam_pkg::RST_MODULUS, cam_pkg::RST_MULTIPLIER,
             cam_pkg::RST_ADDEND, cam_pkg::RST_INVERSE};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed items at the default keys: field extremes in both modes, a decoded
    // index below the offset, and codes above the modulus.
    it = '0;                                      push_item(it);
    it = '0; it.index_in = '1; it.offset = '1;    push_item(it);
    it = '0; it.index_in = '1;                    push_item(it);
    it = '0; it.offset = '1;                      push_item(it);
    it = '0; it.index_in = 59'd12345;             push_item(it);
    it = '0; it.mode = 1'b1;                      push_item(it);
    it = '0; it.mode = 1'b1; it.offset = '1;      push_item(it);
    it = '0; it.mode = 1'b1; it.code_a_in = '1; it.code_b_in = '1; push_item(it);
    it = '0; it.mode = 1'b1;
    it.code_a_in = cam_pkg::RST_ADDEND; it.code_b_in = cam_pkg::RST_ADDEND;
    it.offset = 30'd5;                            push_item(it);
    it = '1; it.mode = 1'b0;                      push_item(it);
    it = '1;                                      push_item(it);
    drain();

    // Zero moduli: encode flags both halves and decode treats halves as zero.
    write_key(cam_pkg::CFG_MODULUS_A, 30'd0);
    write_key(cam_pkg::CFG_MODULUS_B, 30'd0);
    it = '0; it.index_in = 59'd77;                push_item(it);
    it = '0; it.mode = 1'b1; it.code_a_in = 30'd9; push_item(it);
    drain();

    // Modulus of one, and all-ones keys that exceed any modulus below them.
    write_key(cam_pkg::CFG_MODULUS_A, 30'd1);
    write_key(cam_pkg::CFG_MODULUS_B, '1);
    write_key(cam_pkg::CFG_MULTIPLIER_A, '1);
    write_key(cam_pkg::CFG_MULTIPLIER_B, '1);
    write_key(cam_pkg::CFG_ADDEND_A, '1);
    write_key(cam_pkg::CFG_ADDEND_B, '1);
    write_key(cam_pkg::CFG_INVERSE_A, '1);
    write_key(cam_pkg::CFG_INVERSE_B, '1);
    it = '0; it.index_in = 59'd3;                 push_item(it);
    it = '0; it.mode = 1'b1; it.code_a_in = '1; it.code_b_in = 30'd2; push_item(it);
    rand_phase(200);
    drain();

    // Small prime moduli so that most encodes hit the not-invertible case.
    write_key(cam_pkg::CFG_MODULUS_A, 30'd101);
    write_key(cam_pkg::CFG_MULTIPLIER_A, 30'd7);
    write_key(cam_pkg::CFG_ADDEND_A, 30'd200);
    write_key(cam_pkg::CFG_INVERSE_A, 30'd29);
    write_key(cam_pkg::CFG_MODULUS_B, 30'd97);
    write_key(cam_pkg::CFG_MULTIPLIER_B, 30'd0);
    write_key(cam_pkg::CFG_ADDEND_B, 30'd3);
    write_key(cam_pkg::CFG_INVERSE_B, 30'd0);
    rand_phase(300);
    // Hold the sender until every outstanding result has come back.
    while (expected_results.size() > 0) @(posedge clk);
    rand_phase(100);
    drain();

    // Random keys with the large default-size modulus scale.
    write_key(cam_pkg::CFG_MODULUS_A, 30'($urandom_range(2, 30'h3FFFFFFF)));
    write_key(cam_pkg::CFG_MULTIPLIER_A, 30'($urandom));
    write_key(cam_pkg::CFG_ADDEND_A, 30'($urandom));
    write_key(cam_pkg::CFG_INVERSE_A, 30'($urandom));
    write_key(cam_pkg::CFG_MODULUS_B, 30'($urandom_range(2, 30'h3FFFFFFF)));
    write_key(cam_pkg::CFG_MULTIPLIER_B, 30'($urandom));
    write_key(cam_pkg::CFG_ADDEND_B, 30'($urandom));
    write_key(cam_pkg::CFG_INVERSE_B, 30'($urandom));
    rand_phase(400);
    drain();

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
